[rtl/integer_radix_digit_converter_top_assert.svh]
// Assertion macros for the checker file of the radix converter.
`ifndef INTEGER_RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH
`define INTEGER_RADIX_DIGIT_CONVERTER_TOP_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define RDC_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define RDC_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/rdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    // Fixed field widths
    localparam int VALUE_W   = 64;
    localparam int BASE_W    = 6;
    localparam int MIN_DIG_W = 7;
    localparam int CHAR_W    = 7;
    localparam int DIGIT_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    // Parameter defaults
    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_DIGITS = 64;

    // Quotient bits resolved per divider cycle
    localparam int DIV_STEPS = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 1'b1;

    // Operation codes
    localparam logic OP_SCAN    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Base limits and reset value
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_LOW   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_HIGH  = 6'd36;

    // Character set: '0'..'9' then 'A'..'Z'
    localparam logic [DIGIT_W-1:0] DIGIT_LAST    = 6'd35;
    localparam logic [DIGIT_W-1:0] DIGIT_ALPHA   = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA_OFS = 7'd55;

    typedef struct packed {
        logic [BASE_W-1:0]    base;
        logic [MIN_DIG_W-1:0] min_digits;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] base;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } t_div_rsp;

    // Digit value to ASCII
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] c;
        c = (d > DIGIT_LAST) ? DIGIT_LAST : d;
        if (c < DIGIT_ALPHA) begin
            return CHAR_ZERO + {1'b0, c};
        end
        return CHAR_ALPHA_OFS + {1'b0, c};
    endfunction

endpackage

`default_nettype wire

[rtl/rdc_div_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared restoring divider: value / base, STEPS quotient bits per cycle.
module rdc_div_unit #(
    parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  rdc_pkg::t_div_req        i_req,
    input  wire  [VALUE_BITS-1:0]    i_dividend,
    output rdc_pkg::t_div_rsp        o_rsp,
    output logic [VALUE_BITS-1:0]    o_quot
);

    localparam int STEPS  = rdc_pkg::DIV_STEPS;
    localparam int PASSES = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int WORK_W = PASSES * STEPS;
    localparam int CNT_W  = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int REM_W  = rdc_pkg::DIGIT_W;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORK_W-1:0] r_work;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_base;

    logic [WORK_W-1:0] n_work;
    logic [REM_W-1:0]  n_rem;

    // One pass: shift in STEPS dividend bits, quotient bits shift in at the bottom
    always_comb begin
        logic [REM_W:0] trial;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < STEPS; k++) begin
            trial  = {n_rem, n_work[WORK_W-1]};
            n_work = {n_work[WORK_W-2:0], 1'b0};
            if (trial >= {1'b0, r_base}) begin
                trial     = trial - {1'b0, r_base};
                n_work[0] = 1'b1;
            end
            n_rem = trial[REM_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt  <= CNT_W'(PASSES - 1);
            r_work <= WORK_W'(i_dividend);
            r_rem  <= '0;
            r_base <= i_req.base;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_quot     = r_work[VALUE_BITS-1:0];
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

[rtl/rdc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: running maximum, digit store, width logic and character output.
module rdc_ctrl #(
    parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  wire                               i_operation,
    input  wire  [rdc_pkg::VALUE_W-1:0]       i_value,
    input  wire                               i_first_of_array,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic [rdc_pkg::CHAR_W-1:0]        o_char_code,
    output logic                              o_last_char,
    input  wire                               i_out_stall,
    input  rdc_pkg::t_cfg                     i_cfg,
    output rdc_pkg::t_div_req                 o_div_req,
    output logic [VALUE_BITS-1:0]             o_dividend,
    input  rdc_pkg::t_div_rsp                 i_div_rsp,
    input  wire  [VALUE_BITS-1:0]             i_div_quot
);

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int MD_W   = rdc_pkg::MIN_DIG_W;
    localparam logic [MD_W-1:0]  MD_CAP  = MD_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV_V = 5'b00010,
        S_DIV_M = 5'b00100,
        S_READ  = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0]           r_max;
    logic                            r_need_m;
    logic [CNT_W-1:0]                r_own;
    logic [CNT_W-1:0]                r_mcnt;
    logic [ADDR_W-1:0]               r_pos;
    logic [rdc_pkg::DIGIT_W-1:0]     r_rd;
    logic                            r_ovalid;
    logic [rdc_pkg::CHAR_W-1:0]      r_char;
    logic                            r_last;
    logic [rdc_pkg::DIGIT_W-1:0]     r_digits [MAX_DIGITS];

    logic [VALUE_BITS-1:0]       w_value;
    logic                        w_accept;
    logic                        w_done;
    logic                        w_quot_zero;
    logic [CNT_W-1:0]            n_own;
    logic [CNT_W-1:0]            n_mcnt;
    logic                        w_own_end;
    logic                        w_m_end;
    logic [CNT_W-1:0]            w_own_f;
    logic [CNT_W-1:0]            w_m_f;
    logic [CNT_W-1:0]            w_md_sat;
    logic [CNT_W-1:0]            w_width;
    logic [ADDR_W-1:0]           w_pos_start;
    logic                        w_out_free;
    logic [rdc_pkg::DIGIT_W-1:0] w_digit;

    assign w_value     = i_value[VALUE_BITS-1:0];
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_done      = i_div_rsp.done;
    assign w_quot_zero = (i_div_quot == '0);
    assign n_own       = r_own + CNT_W'(1);
    assign n_mcnt      = r_mcnt + CNT_W'(1);
    assign w_own_end   = w_quot_zero || (n_own == CNT_MAX);
    assign w_m_end     = w_quot_zero || (n_mcnt == CNT_MAX);
    assign w_out_free  = !r_ovalid || !i_out_stall;

    // Output width: largest of own count, maximum's count and saturated minimum
    always_comb begin
        w_own_f  = (r_state == S_DIV_V) ? n_own : r_own;
        w_m_f    = (r_state == S_DIV_M) ? n_mcnt : '0;
        w_md_sat = (i_cfg.min_digits > MD_CAP) ? CNT_MAX : CNT_W'(i_cfg.min_digits);
        w_width  = w_own_f;
        if (w_m_f > w_width) begin
            w_width = w_m_f;
        end
        if (w_md_sat > w_width) begin
            w_width = w_md_sat;
        end
        w_pos_start = ADDR_W'(w_width - CNT_W'(1));
    end

    // Positions above the value's own digits are leading zeros
    assign w_digit = (CNT_W'(r_pos) < r_own) ? r_rd : '0;

    // Divider requests
    always_comb begin
        o_div_req.start = 1'b0;
        o_div_req.base  = i_cfg.base;
        o_dividend      = i_div_quot;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == rdc_pkg::OP_CONVERT)) begin
                    o_div_req.start = 1'b1;
                    o_dividend      = w_value;
                end
            end
            S_DIV_V: begin
                if (w_done && !w_own_end) begin
                    o_div_req.start = 1'b1;
                end else if (w_done && r_need_m) begin
                    o_div_req.start = 1'b1;
                    o_dividend      = r_max;
                end
            end
            S_DIV_M: begin
                if (w_done && !w_m_end) begin
                    o_div_req.start = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == rdc_pkg::OP_CONVERT)) begin
                    n_state = S_DIV_V;
                end
            end
            S_DIV_V: begin
                if (w_done && w_own_end) begin
                    n_state = r_need_m ? S_DIV_M : S_READ;
                end
            end
            S_DIV_M: begin
                if (w_done && w_m_end) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_state = (r_pos == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_max    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_operation == rdc_pkg::OP_SCAN)) begin
                if (i_first_of_array || (w_value > r_max)) begin
                    r_max <= w_value;
                end
            end
            if ((r_state == S_LOAD) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Counters, position and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_own    <= '0;
            r_mcnt   <= '0;
            r_need_m <= (r_max > w_value);
        end
        if ((r_state == S_DIV_V) && w_done) begin
            r_own <= n_own;
            if (w_own_end && !r_need_m) begin
                r_pos <= w_pos_start;
            end
        end
        if ((r_state == S_DIV_M) && w_done) begin
            r_mcnt <= n_mcnt;
            if (w_m_end) begin
                r_pos <= w_pos_start;
            end
        end
        if ((r_state == S_LOAD) && w_out_free) begin
            r_char <= rdc_pkg::digit_char(w_digit);
            r_last <= (r_pos == '0);
            if (r_pos != '0) begin
                r_pos <= r_pos - ADDR_W'(1);
            end
        end
    end

    // Digit store: written least significant first, read back from the top
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV_V) && w_done) begin
            r_digits[r_own[ADDR_W-1:0]] <= i_div_rsp.rem;
        end
        if (r_state == S_READ) begin
            r_rd <= r_digits[r_pos];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

[rtl/integer_radix_digit_converter_top.sv]
// Integer to radix string converter, base 2 to 36, uppercase ASCII digits.
// Input channel (i_in_valid / o_in_stall): a scan item (operation 0) folds its
// value into the running maximum (first_of_array restarts it) and yields no
// characters; a convert item (operation 1) yields its digits most significant
// first, zero padded to max(min_digits, digits of the maximum, own digits),
// capped at MAX_DIGITS, one character per transfer, last_char on the final one.
// Output channel (o_out_valid / i_out_stall): a character is held in the
// output register until taken; while stalled the sequencer waits to load.
// Sequence: a scan item only updates the maximum. A convert item divides
// the value, and then the maximum only when it is larger, digit by digit
// in the shared divider, which resolves 8 quotient bits per cycle; each
// character then needs a digit store read and an output load.
// Input is stalled during a conversion; the last character may still wait
// in the output register while the next item is taken.
// Configuration writes (base, min_digits) are taken at any edge with i_cfg_we.
// Reset (synchronous, active low): base 10, min_digits 0, maximum 0, idle.
`timescale 1ns / 1ps
`default_nettype none

module integer_radix_digit_converter_top #(
    parameter int VALUE_BITS = rdc_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = rdc_pkg::DEF_MAX_DIGITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [rdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rdc_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_operation,
    input  wire  [rdc_pkg::VALUE_W-1:0]        i_value,
    input  wire                                i_first_of_array,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [rdc_pkg::CHAR_W-1:0]         o_char_code,
    output logic                               o_last_char
);

    logic [rdc_pkg::BASE_W-1:0]    r_base;
    logic [rdc_pkg::MIN_DIG_W-1:0] r_min_digits;

    rdc_pkg::t_cfg          w_cfg;
    rdc_pkg::t_div_req      w_div_req;
    rdc_pkg::t_div_rsp      w_div_rsp;
    logic [VALUE_BITS-1:0]  w_dividend;
    logic [VALUE_BITS-1:0]  w_div_quot;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= rdc_pkg::BASE_RESET;
            r_min_digits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rdc_pkg::CFG_BASE: begin
                    r_base <= i_cfg_data[rdc_pkg::BASE_W-1:0];
                end
                rdc_pkg::CFG_MIN_DIGITS: begin
                    r_min_digits <= i_cfg_data[rdc_pkg::MIN_DIG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp base into 2..36
    always_comb begin
        if (r_base < rdc_pkg::BASE_LOW) begin
            w_cfg.base = rdc_pkg::BASE_LOW;
        end else if (r_base > rdc_pkg::BASE_HIGH) begin
            w_cfg.base = rdc_pkg::BASE_HIGH;
        end else begin
            w_cfg.base = r_base;
        end
        w_cfg.min_digits = r_min_digits;
    end

    rdc_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .o_rsp      (w_div_rsp),
        .o_quot     (w_div_quot)
    );

    rdc_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_first_of_array (i_first_of_array),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .o_char_code      (o_char_code),
        .o_last_char      (o_last_char),
        .i_out_stall      (i_out_stall),
        .i_cfg            (w_cfg),
        .o_div_req        (w_div_req),
        .o_dividend       (w_dividend),
        .i_div_rsp        (w_div_rsp),
        .i_div_quot       (w_div_quot)
    );

endmodule

`default_nettype wire

[rtl/rdc_port_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "integer_radix_digit_converter_top_assert.svh"

// Port-level checks for the radix converter.
module rdc_port_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           o_in_stall,
    input wire                           i_operation,
    input wire                           o_out_valid,
    input wire                           i_out_stall,
    input wire [rdc_pkg::CHAR_W-1:0]     o_char_code,
    input wire                           o_last_char
);

    // A stalled character holds
    `RDC_CHECK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_char_code) && $stable(o_last_char), "stalled character changed")

    // Only digits and uppercase letters leave the block
    `RDC_CHECK(a_char_legal, i_clk, i_rst_n, o_out_valid |-> ((o_char_code >= 7'd48 && o_char_code <= 7'd57) || (o_char_code >= 7'd65 && o_char_code <= 7'd90)), "illegal character code")

    // A scan transfer leaves the block ready
    `RDC_CHECK(a_scan_ready, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_operation == rdc_pkg::OP_SCAN) |=> !o_in_stall, "not ready after scan")

    // A convert transfer starts the divider sequence
    `RDC_CHECK(a_conv_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_operation == rdc_pkg::OP_CONVERT) |=> o_in_stall, "not busy after convert")

    // Reset empties the output register
    `RDC_CHECK_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind integer_radix_digit_converter_top rdc_port_checker u_rdc_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_W        = rdc_pkg::VALUE_W;
    localparam int CHAR_W         = rdc_pkg::CHAR_W;
    localparam int CFG_IDX_W      = rdc_pkg::CFG_IDX_W;
    localparam int CFG_W          = rdc_pkg::CFG_W;
    localparam int BASE_W         = rdc_pkg::BASE_W;
    localparam int MIN_DIG_W      = rdc_pkg::MIN_DIG_W;
    localparam int DIGIT_W        = rdc_pkg::DIGIT_W;
    localparam int MAX_DIGITS     = 64;
    localparam int QUIET_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 500;
    localparam int ITEM_TARGET    = 260;
    localparam int IDLE_PCT       = 8;
    localparam int MAX_REPORTS    = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
        logic               first;
    } t_conv_item;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char;

    // DUT connections, all inputs known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = rdc_pkg::CFG_BASE;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_op     = rdc_pkg::OP_SCAN;
    logic [VALUE_W-1:0]   in_value  = '0;
    logic                 in_first  = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic [CHAR_W-1:0]    char_code;
    logic                 last_char;

    // Stimulus and expectation stores
    t_conv_item item_queue[$];
    t_char      expected_chars[$];
    t_conv_item next_item;
    t_char      want;
    int         queued_items = 0;
    int         taken_items  = 0;
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    int         hold_left    = 0;
    bit         in_fire      = 1'b0;
    bit         calm         = 1'b0;
    bit         hold_req     = 1'b0;
    bit         hold_done    = 1'b0;

    // Predictor state
    logic [VALUE_W-1:0] max_seen      = '0;
    logic [BASE_W-1:0]  radix_reg     = rdc_pkg::BASE_RESET;
    logic [MIN_DIG_W-1:0] min_width_reg = '0;

    integer_radix_digit_converter_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (in_op),
        .i_value          (in_value),
        .i_first_of_array (in_first),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_char_code      (char_code),
        .o_last_char      (last_char)
    );

    always #2 clk = ~clk;

    function automatic int count_digits(logic [VALUE_W-1:0] v, logic [VALUE_W-1:0] b);
        int n;
        n = 1;
        while (v >= b) begin
            v = v / b;
            n++;
        end
        return n;
    endfunction

    // Scan folds into the maximum; convert queues the padded digit string
    function automatic void predict_chars(logic op, logic [VALUE_W-1:0] value, logic first);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] b;
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        int   width;
        int   own;
        int   floor_w;
        t_char c;
        if (op == rdc_pkg::OP_SCAN) begin
            if (first || value > max_seen) max_seen = value;
        end else begin
            if (radix_reg < rdc_pkg::BASE_LOW) b = VALUE_W'(rdc_pkg::BASE_LOW);
            else if (radix_reg > rdc_pkg::BASE_HIGH) b = VALUE_W'(rdc_pkg::BASE_HIGH);
            else b = VALUE_W'(radix_reg);
            width = count_digits(max_seen, b);
            own = count_digits(value, b);
            if (own > width) width = own;
            floor_w = (min_width_reg > MAX_DIGITS) ? MAX_DIGITS : int'(min_width_reg);
            if (floor_w > width) width = floor_w;
            if (width > MAX_DIGITS) width = MAX_DIGITS;
            v = value;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digits[i] = DIGIT_W'(v % b);
                v = v / b;
            end
            // most significant digit first
            for (int i = width - 1; i >= 0; i--) begin
                if (digits[i] < 10) c.code = ASCII_ZERO + CHAR_W'(digits[i]);
                else c.code = ASCII_A + CHAR_W'(digits[i]) - 7'd10;
                c.last = (i == 0);
                expected_chars.insert(expected_chars.size(), c);
            end
        end
    endfunction

    task automatic report(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: got char %0d last %0d, expected char %0d last %0d",
                     what, char_code, last_char, want.code, want.last);
        end
    endtask

    // Sample transfers, register writes and results at the rising edge
    always @(posedge clk) begin
        in_fire = in_valid && !in_stall;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_index == rdc_pkg::CFG_BASE) radix_reg = cfg_data[BASE_W-1:0];
                else min_width_reg = cfg_data[MIN_DIG_W-1:0];
            end
            if (in_fire) begin
                predict_chars(in_op, in_value, in_first);
                taken_items++;
            end
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    want = '0;
                    report("unexpected character");
                end else begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.code || last_char !== want.last) begin
                        report("character mismatch");
                    end
                end
            end
        end
    end

    // Input driver: next item after a transfer, random gaps unless calm
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (item_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item = item_queue.pop_front();
                in_valid <= 1'b1;
                in_op    <= next_item.op;
                in_value <= next_item.value;
                in_first <= next_item.first;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random, plus one long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push(logic op, logic [VALUE_W-1:0] value, logic first);
        t_conv_item entry;
        entry.op    = op;
        entry.value = value;
        entry.first = first;
        item_queue.insert(item_queue.size(), entry);
        queued_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] base_data, logic [CFG_W-1:0] min_data);
        write_reg(rdc_pkg::CFG_BASE, base_data);
        write_reg(rdc_pkg::CFG_MIN_DIGITS, min_data);
    endtask

    // Wait until every item is taken and every character has arrived
    task automatic settle();
        while (taken_items != queued_items || expected_chars.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return VALUE_W'($urandom_range(0, 40));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_base();
        logic [BASE_W-1:0] b;
        case ($urandom_range(0, 9))
            0: b = BASE_W'($urandom_range(0, 63));
            1: b = $urandom_range(0, 1) ? rdc_pkg::BASE_HIGH : rdc_pkg::BASE_LOW;
            default: b = BASE_W'($urandom_range(3, 36));
        endcase
        return {1'($urandom_range(0, 1)), b};
    endfunction

    function automatic logic [CFG_W-1:0] pick_min();
        case ($urandom_range(0, 7))
            0: return CFG_W'($urandom_range(0, 127));
            1: return 7'd64;
            default: return CFG_W'($urandom_range(0, 24));
        endcase
    endfunction

    // Arrays sent twice: scan pass then convert pass, with some noise
    task automatic random_phase();
        logic [VALUE_W-1:0] vals[$];
        int n_arrays;
        int len;
        set_regs(pick_base(), pick_min());
        n_arrays = $urandom_range(1, 4);
        repeat (n_arrays) begin
            vals.delete();
            len = $urandom_range(1, 6);
            repeat (len) vals.insert(vals.size(), rand_value());
            foreach (vals[i]) begin
                push(rdc_pkg::OP_SCAN, vals[i],
                     (i == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 19) == 0);
            end
            foreach (vals[i]) push(rdc_pkg::OP_CONVERT, vals[i], 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                push(1'($urandom_range(0, 1)), rand_value(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int phase;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero, full range, padding, ignored first mark
        push(rdc_pkg::OP_SCAN, '0, 1'b1);
        push(rdc_pkg::OP_CONVERT, '0, 1'b0);
        push(rdc_pkg::OP_SCAN, '1, 1'b1);
        push(rdc_pkg::OP_CONVERT, '1, 1'b0);
        push(rdc_pkg::OP_CONVERT, 64'd5, 1'b0);
        push(rdc_pkg::OP_CONVERT, 64'd9, 1'b1);
        push(rdc_pkg::OP_SCAN, 64'd100, 1'b1);
        push(rdc_pkg::OP_SCAN, 64'd7, 1'b0);
        push(rdc_pkg::OP_SCAN, 64'd1000, 1'b0);
        push(rdc_pkg::OP_CONVERT, 64'd7, 1'b0);
        // value never scanned and above the maximum
        push(rdc_pkg::OP_CONVERT, 64'd123456789, 1'b0);
        settle();

        set_regs(7'd36, 7'd0);
        push(rdc_pkg::OP_SCAN, '1, 1'b1);
        push(rdc_pkg::OP_CONVERT, 64'd35, 1'b0);
        push(rdc_pkg::OP_CONVERT, '1, 1'b0);
        settle();

        // base below range with full padding
        set_regs(7'd0, 7'd64);
        push(rdc_pkg::OP_CONVERT, '1, 1'b0);
        push(rdc_pkg::OP_CONVERT, 64'd1, 1'b0);
        settle();

        // base above range, padding beyond the digit limit
        set_regs(7'h3F, 7'h7F);
        push(rdc_pkg::OP_CONVERT, '0, 1'b0);
        settle();

        set_regs(7'd1, 7'd3);
        push(rdc_pkg::OP_SCAN, 64'd5, 1'b1);
        push(rdc_pkg::OP_CONVERT, 64'd5, 1'b0);
        settle();

        set_regs(7'd16, 7'd0);
        push(rdc_pkg::OP_CONVERT, 64'h8000_0000_0000_0000, 1'b0);
        push(rdc_pkg::OP_CONVERT, 64'hFEDC_BA98_7654_3210, 1'b0);
        settle();

        set_regs(7'd37, 7'd65);
        push(rdc_pkg::OP_CONVERT, 64'd12345, 1'b0);
        settle();

        // Random phases; one with a long output hold-off, two without gaps
        phase = 0;
        while (queued_items < ITEM_TARGET) begin
            if (phase == 1) hold_req = 1'b1;
            calm = (phase == 3 || phase == 4);
            random_phase();
            settle();
            phase++;
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
